FILE: rtl/tkss_pkg.sv
// ----------------------------------------------------------------------------
// tkss_pkg
// shared constants, codes and types of the top-k insertion sorter
// ----------------------------------------------------------------------------
package tkss_pkg;

  localparam int SLOTS_DEF       = 16;
  localparam int VERTEX_BITS_DEF = 20;
  localparam int DIST_BITS_DEF   = 16;

  localparam int K_BITS    = 5;
  localparam int WIDE_BITS = 7;
  localparam logic [K_BITS-1:0] K_RESET = 5'd16;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_CLEAR  = 2'd1;
  localparam logic [1:0] MODE_READ   = 2'd2;

  typedef struct packed {
    logic ins;
    logic rot;
  } cell_ctl_t;

  // zero acts as one, anything above the slot count acts as the slot count
  function automatic logic [WIDE_BITS-1:0] eff_k(input logic [K_BITS-1:0] k,
                                                 input logic [WIDE_BITS-1:0] slots);
    logic [WIDE_BITS-1:0] kw;
    kw = WIDE_BITS'(k);
    if (kw == '0) begin
      kw = WIDE_BITS'(1);
    end
    if (kw > slots) begin
      kw = slots;
    end
    return kw;
  endfunction

endpackage

FILE: rtl/tkss_cell.sv
// ----------------------------------------------------------------------------
// tkss_cell
// one slot of the sorted list: compare, insert, shift right or rotate left
// ----------------------------------------------------------------------------
module tkss_cell
  import tkss_pkg::*;
#(
  parameter int IDX         = 0,
  parameter int CNT_W       = 5,
  parameter int VERTEX_BITS = VERTEX_BITS_DEF,
  parameter int DIST_BITS   = DIST_BITS_DEF
) (
  input  logic                   clk,
  input  cell_ctl_t              ctl,
  input  logic [CNT_W-1:0]       held,
  input  logic [VERTEX_BITS-1:0] new_vertex,
  input  logic [DIST_BITS-1:0]   new_dist,
  input  logic                   left_le,
  input  logic [VERTEX_BITS-1:0] left_vertex,
  input  logic [DIST_BITS-1:0]   left_dist,
  input  logic [VERTEX_BITS-1:0] right_vertex,
  input  logic [DIST_BITS-1:0]   right_dist,
  input  logic [VERTEX_BITS-1:0] head_vertex,
  input  logic [DIST_BITS-1:0]   head_dist,
  output logic [VERTEX_BITS-1:0] vertex,
  output logic [DIST_BITS-1:0]   dist_val,
  output logic                   le
);

  logic occ;
  logic tail;

  assign occ  = CNT_W'(IDX) < held;
  assign tail = CNT_W'(IDX + 1) == held;
  assign le   = occ && (dist_val <= new_dist);

  always_ff @(posedge clk) begin
    if (ctl.ins && !le) begin
      if (IDX == 0 || left_le) begin
        vertex   <= new_vertex;
        dist_val <= new_dist;
      end else begin
        vertex   <= left_vertex;
        dist_val <= left_dist;
      end
    end else if (ctl.rot) begin
      if (tail) begin
        vertex   <= head_vertex;
        dist_val <= head_dist;
      end else begin
        vertex   <= right_vertex;
        dist_val <= right_dist;
      end
    end
  end

endmodule

FILE: rtl/top_k_smallest_sorted_insert_top.sv
// ----------------------------------------------------------------------------
// top_k_smallest_sorted_insert_top
// keeps the k smallest (vertex, distance) pairs in ascending order
// ----------------------------------------------------------------------------
// An insert, clear or unknown command gives one result beat in the next
// cycle, so these run at one command per cycle while no read is running. A
// read of n held entries returns them in order: the row of cells rotates by
// one slot per cycle and the head cell feeds the result port, so busy stays
// high until the head cell has fed the last entry, and one beat leaves per
// cycle. Reading an empty list gives one beat. Result beats are shown for one
// cycle only on result_valid; the receiver cannot stall them. k_in_use is
// written through cfg while busy and start are low.
// ----------------------------------------------------------------------------
module top_k_smallest_sorted_insert_top
  import tkss_pkg::*;
#(
  parameter int SLOTS       = SLOTS_DEF,
  parameter int VERTEX_BITS = VERTEX_BITS_DEF,
  parameter int DIST_BITS   = DIST_BITS_DEF,
  localparam int CNT_W      = $clog2(SLOTS + 1),
  localparam int IW         = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [1:0]             mode,
  input  logic [VERTEX_BITS-1:0] vertex_id,
  input  logic [DIST_BITS-1:0]   distance,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [K_BITS-1:0]      cfg_data,
  output logic                   result_valid,
  output logic [VERTEX_BITS-1:0] entry_vertex,
  output logic [DIST_BITS-1:0]   entry_distance,
  output logic                   entry_valid,
  output logic                   accepted,
  output logic [CNT_W-1:0]       held_count,
  output logic                   last
);

  localparam logic [WIDE_BITS-1:0] SLOTS_W = WIDE_BITS'(SLOTS);

  logic [K_BITS-1:0] k_in_use;
  logic [CNT_W-1:0]  held;
  logic [CNT_W-1:0]  held_next;
  logic              reading;
  logic [CNT_W-1:0]  rd_cnt;

  logic [CNT_W-1:0] effk;
  logic [CNT_W-1:0] effk_cfg;
  logic             take;
  logic             cfg_take;
  logic             full;
  logic             dist_ok;
  logic             acc;
  logic             rd_last;
  cell_ctl_t        ctl;

  logic [VERTEX_BITS-1:0] cell_vertex [SLOTS];
  logic [DIST_BITS-1:0]   cell_dist   [SLOTS];
  logic [SLOTS-1:0]       cell_le;

  assign busy      = reading;
  assign cfg_ready = !reading && !start;
  assign take      = start && !busy;
  assign cfg_take  = cfg_valid && cfg_ready;

  assign effk     = CNT_W'(eff_k(k_in_use, SLOTS_W));
  assign effk_cfg = CNT_W'(eff_k(cfg_data, SLOTS_W));

  assign full    = held >= effk;
  assign dist_ok = distance != {DIST_BITS{1'b1}};
  assign acc     = dist_ok && (!full || !cell_le[IW'(effk - CNT_W'(1))]);
  assign rd_last = (rd_cnt + CNT_W'(1)) == held;

  assign ctl.ins = take && (mode == MODE_INSERT) && acc;
  assign ctl.rot = reading;

  always_comb begin
    held_next = held;
    if (take) begin
      case (mode)
        MODE_INSERT: begin
          if (acc && !full) begin
            held_next = held + CNT_W'(1);
          end
        end
        MODE_CLEAR: held_next = '0;
        default:    held_next = held;
      endcase
    end else if (cfg_take && held > effk_cfg) begin
      held_next = effk_cfg;
    end
  end

  genvar g;
  generate
    for (g = 0; g < SLOTS; g++) begin : g_cell
      logic [VERTEX_BITS-1:0] lv;
      logic [DIST_BITS-1:0]   ld;
      logic                   lle;
      logic [VERTEX_BITS-1:0] rv;
      logic [DIST_BITS-1:0]   rd;
      if (g == 0) begin : g_first
        assign lv  = vertex_id;
        assign ld  = distance;
        assign lle = 1'b0;
      end else begin : g_mid
        assign lv  = cell_vertex[g-1];
        assign ld  = cell_dist[g-1];
        assign lle = cell_le[g-1];
      end
      if (g == SLOTS - 1) begin : g_end
        assign rv = cell_vertex[0];
        assign rd = cell_dist[0];
      end else begin : g_inner
        assign rv = cell_vertex[g+1];
        assign rd = cell_dist[g+1];
      end
      tkss_cell #(
        .IDX         (g),
        .CNT_W       (CNT_W),
        .VERTEX_BITS (VERTEX_BITS),
        .DIST_BITS   (DIST_BITS)
      ) u_cell (
        .clk          (clk),
        .ctl          (ctl),
        .held         (held),
        .new_vertex   (vertex_id),
        .new_dist     (distance),
        .left_le      (lle),
        .left_vertex  (lv),
        .left_dist    (ld),
        .right_vertex (rv),
        .right_dist   (rd),
        .head_vertex  (cell_vertex[0]),
        .head_dist    (cell_dist[0]),
        .vertex       (cell_vertex[g]),
        .dist_val     (cell_dist[g]),
        .le           (cell_le[g])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      k_in_use     <= K_RESET;
      held         <= '0;
      reading      <= 1'b0;
      rd_cnt       <= '0;
      result_valid <= 1'b0;
    end else begin
      held         <= held_next;
      result_valid <= 1'b0;
      if (cfg_take) begin
        k_in_use <= cfg_data;
      end
      if (reading) begin
        result_valid <= 1'b1;
        rd_cnt       <= rd_cnt + CNT_W'(1);
        if (rd_last) begin
          reading <= 1'b0;
        end
      end else if (take) begin
        if (mode == MODE_READ && held != '0) begin
          reading <= 1'b1;
          rd_cnt  <= '0;
        end else begin
          result_valid <= 1'b1;
        end
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (reading) begin
      entry_vertex   <= cell_vertex[0];
      entry_distance <= cell_dist[0];
      entry_valid    <= 1'b1;
      accepted       <= 1'b0;
      held_count     <= held;
      last           <= rd_last;
    end else if (take) begin
      entry_vertex   <= '0;
      entry_distance <= '0;
      entry_valid    <= 1'b0;
      accepted       <= (mode == MODE_INSERT) && acc;
      held_count     <= held_next;
      last           <= 1'b1;
    end
  end

  a_held_bound : assert property (@(posedge clk) disable iff (rst)
    held <= effk || $past(cfg_take))
    else $error("held count above k");

  a_read_beat : assert property (@(posedge clk) disable iff (rst)
    reading |=> result_valid && entry_valid)
    else $error("read cycle without a beat");

  a_unreachable : assert property (@(posedge clk) disable iff (rst)
    take && mode == MODE_INSERT && !dist_ok |=> result_valid && !accepted)
    else $error("unreachable distance entered the list");

  a_not_last_busy : assert property (@(posedge clk) disable iff (rst)
    result_valid && !last |-> busy)
    else $error("inner read beat while idle");

endmodule
